[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file ftip_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[hw/rtl/ftip_pkg.sv]
// ----------------------------------------------------------------------------
// ftip_pkg
// Shared constants and the float to nibble quantizer.
// ----------------------------------------------------------------------------
package ftip_pkg;
  localparam int BlkElems = 32;
  localparam int BlkRows  = 8;
  localparam int BlkCols  = 4;
  localparam int IdxW     = 5;
  localparam int CntW     = 26;
  localparam int NibW     = 4;
  localparam logic [1:0] RegTotalBlocks = 2'd0;

  // Truncate toward zero, saturate to -8..7, NaN to zero.
  function automatic logic [3:0] quantize(input logic [31:0] bits);
    logic [7:0] expo;
    logic [22:0] mant;
    logic [3:0] mag;
    logic [3:0] res;
    expo = bits[30:23];
    mant = bits[22:0];
    unique case (expo)
      8'd127: mag = 4'd1;
      8'd128: mag = {2'b00, 1'b1, mant[22]};
      8'd129: mag = {1'b0, 1'b1, mant[22:21]};
      default: mag = (expo > 8'd129) ? 4'd8 : 4'd0;
    endcase
    if (expo == 8'hFF && mant != 23'd0) begin
      res = 4'd0;
    end else if (!bits[31]) begin
      res = (mag > 4'd7) ? 4'd7 : mag;
    end else begin
      res = 4'd0 - mag;
    end
    return res;
  endfunction
endpackage

[hw/rtl/ftip_cell.sv]
// ----------------------------------------------------------------------------
// ftip_cell
// One stage of the nibble shift chain: holds one nibble, passes it on.
// ----------------------------------------------------------------------------
module ftip_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [3:0] din,
  output logic [3:0] dout
);
  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end
endmodule

[hw/rtl/float_to_int4_transpose_pack.sv]
// A word appears in the cycle after the 32nd element of its block is accepted.
// Throughput: one element per cycle while the output is not stalled; the chain of 31
// nibble cells shifts once per accepted element, and the output register is reloaded while a word is taken.
// Reset clears the element and block counters, the output valid and total_blocks.
// Nibble cells hold no reset value; every cell is refilled before each word.
// ----------------------------------------------------------------------------
// float_to_int4_transpose_pack
// Quantizes floats to signed nibbles and emits each 8x4 block column-major.
// ----------------------------------------------------------------------------
module float_to_int4_transpose_pack (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // float_bits[31:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // packed_low[63:0], packed_high[127:64]
  output logic         m_tlast,   // last_block
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [0:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  logic [ftip_pkg::CntW-1:0] total_blocks;
  logic [ftip_pkg::IdxW-1:0] element_index;
  logic [ftip_pkg::CntW-1:0] block_index;
  logic [3:0] chain [ftip_pkg::BlkElems];
  logic [127:0] word;
  logic accept, done, last;

  assign pready   = 1'b1;
  assign prdata   = {6'd0, total_blocks};
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign done     = accept && (element_index == ftip_pkg::IdxW'(ftip_pkg::BlkElems - 1));
  assign last     = (total_blocks != '0) && (block_index == total_blocks - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks <= '0;
    end else if (psel && penable && pwrite && paddr == ftip_pkg::RegTotalBlocks[0:0]) begin
      total_blocks <= pwdata[ftip_pkg::CntW-1:0];
    end
  end

  // chain[0] takes the new nibble; chain[k] holds the element accepted k items ago.
  assign chain[0] = ftip_pkg::quantize(s_tdata);
  for (genvar k = 0; k < ftip_pkg::BlkElems - 1; k++) begin : g_cell
    ftip_cell u_cell (.clk(clk), .shift(accept), .din(chain[k]), .dout(chain[k+1]));
  end

  // Position p = c*8+r holds element e = r*4+c. At completion, element e is
  // chain[31-e] for e<31 and the incoming nibble chain[0] for e=31.
  always_comb begin
    for (int p = 0; p < ftip_pkg::BlkElems; p++) begin
      word[4*p +: 4] = chain[ftip_pkg::BlkElems - 1
        - ((p % ftip_pkg::BlkRows) * ftip_pkg::BlkCols + p / ftip_pkg::BlkRows)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_index <= '0;
      block_index   <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (accept) begin
        element_index <= element_index + 1'b1;
      end
      if (done) begin
        block_index <= last ? '0 : block_index + 1'b1;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_tdata <= word;
      m_tlast <= last;
    end
  end
endmodule

[hw/rtl/ftip_checker.sv]
// ----------------------------------------------------------------------------
// ftip_checker
// Port-level checks of the packing stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ftip_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata,
  input logic         pready
);
  `CHK_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output dropped")
  `CHK_IMPLY(a_ready, clk, rst, !m_tvalid, s_tready, "input stalled without pending word")
  `CHK_IMPLY(a_pready, clk, rst, 1'b1, pready, "pready low")
  `CHK_NEXT(a_gap, clk, rst, m_tvalid && m_tready, !m_tvalid || $past(s_tvalid && s_tready), "word from nothing")
endmodule

bind float_to_int4_transpose_pack ftip_checker u_chk (.*);
